/* src/cba_pkg.sv */
// Shared types and constants for the contiguous block allocator.
`default_nettype none
package cba_pkg;
	localparam int MaxBlocks = 16;
	localparam int AddrBits  = 16;
	localparam int IdxW      = $clog2(MaxBlocks);
	localparam int CntW      = $clog2(MaxBlocks + 1);

	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [15:0]         word_t;
	typedef logic [IdxW-1:0]     idx_t;
	typedef logic [CntW-1:0]     cnt_t;

	typedef enum logic [1:0] {
		OP_FIRST = 2'd0,
		OP_BEST  = 2'd1,
		OP_FREE  = 2'd2,
		OP_DEFRAG = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOMEM    = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOHOLE   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_HOLE, S_SHUP, S_SHDN, S_PACK, S_DONE
	} state_t;

	localparam logic [1:0] RegMemSize = 2'd0;

	typedef struct packed {
		logic load;     // capture request, reset pointer
		logic step;     // advance pointer
		logic scan_id;  // compare id at pointer
		logic scan_hole;
		logic shift_up;
		logic shift_dn;
		logic pack;
		logic finish;   // commit and emit
	} cmd_t;

	typedef struct packed {
		logic    at_end;   // pointer reached last index of current walk
		logic    id_hit;
		logic    hole_done;
		logic    no_mem;
		logic    full;
		op_t     op;
	} sts_t;
endpackage
`default_nettype wire

/* src/cba_ctrl.sv */
// Controller state machine for the block allocator.
`default_nettype none
module cba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           cfg_wr,
	input  wire cba_pkg::sts_t  sts,
	output cba_pkg::cmd_t       cmd,
	output logic                busy
);
	import cba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && !cfg_wr) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.op == OP_DEFRAG) state_d = sts.at_end ? S_DONE : S_PACK;
				else if ((sts.op != OP_FREE) && sts.no_mem) state_d = S_DONE;
				else if (sts.id_hit) state_d = (sts.op == OP_FREE) ? S_SHDN : S_DONE;
				else if (sts.at_end) begin
					if (sts.op == OP_FREE) state_d = S_DONE;
					else if (sts.full) state_d = S_DONE;
					else state_d = S_HOLE;
				end
			end
			S_HOLE: begin
				if (sts.hole_done) state_d = S_SHUP;
			end
			S_SHUP: begin
				if (sts.at_end) state_d = S_DONE;
			end
			S_SHDN: begin
				if (sts.at_end) state_d = S_DONE;
			end
			S_PACK: begin
				if (sts.at_end) state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = start;
			S_SCAN: cmd.scan_id = 1'b1;
			S_HOLE: cmd.scan_hole = 1'b1;
			S_SHUP: cmd.shift_up = 1'b1;
			S_SHDN: cmd.shift_dn = 1'b1;
			S_PACK: cmd.pack = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

/* src/cba_dpath.sv */
// Datapath: block table, pointer, hole search, shifting and result words.
`default_nettype none
module cba_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cba_pkg::cmd_t   cmd,
	output cba_pkg::sts_t        sts,
	input  wire logic [1:0]      opcode,
	input  wire logic [15:0]     req_id,
	input  wire logic [15:0]     req_size,
	input  wire logic            cfg_wr,
	input  wire logic [15:0]     cfg_data,
	output logic [15:0]          mem_size,
	output logic                 done,
	output logic [2:0]           status,
	output logic [15:0]          block_start,
	output logic [15:0]          block_end,
	output logic [15:0]          free_remaining
);
	import cba_pkg::*;

	word_t tid_q [MaxBlocks];
	addr_t tst_q [MaxBlocks];
	addr_t ten_q [MaxBlocks];

	cnt_t  count_q;
	word_t rem_q, msize_q;
	op_t   op_q;
	word_t id_q, size_q;
	cnt_t  ptr_q;          // walk index
	cnt_t  pick_q;
	word_t pick_len_q;
	logic  found_q;
	addr_t at_q;
	status_t st_q;
	addr_t rs_q, re_q;
	logic  done_q;

	idx_t  pi;
	addr_t lo, hi, len, elen;
	logic  fits, take;

	assign pi = ptr_q[IdxW-1:0];
	assign lo = (ptr_q == '0) ? '0 : ten_q[IdxW'(ptr_q - 1'b1)];
	assign hi = (ptr_q < count_q) ? tst_q[pi] : addr_t'(msize_q);
	assign len = (hi > lo) ? hi - lo : '0;
	assign elen = (ten_q[pi] > tst_q[pi]) ? ten_q[pi] - tst_q[pi] : '0;
	assign fits = (AddrBits)'(size_q) <= len;
	assign take = fits && (!found_q || (op_q == OP_BEST && len < addr_t'(pick_len_q)));

	always_comb begin
		sts.op = op_q;
		sts.no_mem = size_q > rem_q;
		sts.full = count_q >= cnt_t'(MaxBlocks);
		sts.id_hit = (ptr_q < count_q) && tid_q[pi] == id_q;
		sts.hole_done = (take && op_q == OP_FIRST) || ptr_q == count_q;
		sts.at_end = 1'b0;
		if (cmd.scan_id) sts.at_end = (op_q == OP_DEFRAG) ? (count_q == '0)
			: (ptr_q + 1'b1 >= count_q);
		else if (cmd.shift_up) sts.at_end = (st_q != ST_OK) || (ptr_q <= pick_q);
		else if (cmd.shift_dn || cmd.pack) sts.at_end = ptr_q + 1'b1 >= count_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_up && st_q == ST_OK) begin
			if (ptr_q > pick_q) begin
				tid_q[pi] <= tid_q[IdxW'(ptr_q - 1'b1)];
				tst_q[pi] <= tst_q[IdxW'(ptr_q - 1'b1)];
				ten_q[pi] <= ten_q[IdxW'(ptr_q - 1'b1)];
			end else begin
				tid_q[pi] <= id_q;
				tst_q[pi] <= rs_q;
				ten_q[pi] <= re_q;
			end
		end
		if (cmd.shift_dn && ptr_q + 1'b1 < count_q) begin
			tid_q[pi] <= tid_q[IdxW'(ptr_q + 1'b1)];
			tst_q[pi] <= tst_q[IdxW'(ptr_q + 1'b1)];
			ten_q[pi] <= ten_q[IdxW'(ptr_q + 1'b1)];
		end
		if (cmd.pack) begin
			tst_q[pi] <= at_q;
			ten_q[pi] <= at_q + elen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q <= 16'd4096;
			msize_q <= 16'd4096;
			done_q <= 1'b0;
			ptr_q <= '0;
			found_q <= 1'b0;
			pick_q <= '0;
			pick_len_q <= '0;
			at_q <= '0;
			st_q <= ST_OK;
			rs_q <= '0;
			re_q <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_wr) begin
				msize_q <= cfg_data;
				rem_q <= cfg_data;
				count_q <= '0;
			end
			if (cmd.load) begin
				ptr_q <= '0;
				found_q <= 1'b0;
				at_q <= '0;
				st_q <= ST_OK;
				rs_q <= '0;
				re_q <= '0;
			end
			if (cmd.scan_id) begin
				if (op_q == OP_DEFRAG) begin
					ptr_q <= '0;
				end else if (op_q != OP_FREE && sts.no_mem) begin
					st_q <= ST_NOMEM;
				end else if (sts.id_hit) begin
					if (op_q == OP_FREE) begin
						rs_q <= tst_q[pi];
						re_q <= ten_q[pi];
						rem_q <= rem_q + word_t'(elen);
					end else st_q <= ST_DUP;
				end else if (sts.at_end) begin
					ptr_q <= '0;
					if (op_q == OP_FREE) st_q <= ST_NOTFOUND;
					else if (sts.full) st_q <= ST_FULL;
				end else ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.scan_hole) begin
				if (take) begin
					found_q <= 1'b1;
					pick_q <= ptr_q;
					pick_len_q <= word_t'(len);
					rs_q <= lo;
					re_q <= lo + addr_t'(size_q);
				end
				if (sts.hole_done) begin
					ptr_q <= count_q;
					if (!(take || found_q)) st_q <= ST_NOHOLE;
				end else ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.shift_up && st_q == ST_OK) begin
				if (ptr_q > pick_q) ptr_q <= ptr_q - 1'b1;
				else begin
					count_q <= count_q + 1'b1;
					rem_q <= rem_q - size_q;
				end
			end
			if (cmd.shift_dn) begin
				if (sts.at_end) count_q <= count_q - 1'b1;
				else ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.pack) begin
				at_q <= at_q + elen;
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(opcode);
			id_q <= req_id;
			size_q <= req_size;
		end
	end

	// A failed hole search leaves the table untouched and ends the shift at once.

	assign mem_size = msize_q;
	assign done = done_q;
	assign status = st_q;
	assign block_start = (st_q == ST_OK) ? 16'(rs_q) : '0;
	assign block_end = (st_q != ST_OK) ? '0 : (op_q == OP_DEFRAG) ? 16'(at_q) : 16'(re_q);
	assign free_remaining = rem_q;
endmodule
`default_nettype wire

/* src/contiguous_block_allocator_core.sv */
// Top level of the contiguous block allocator.
// The id scan, hole scan and table shift each walk up to MaxBlocks entries.
// Throughput: one request at a time; busy falls in the cycle of the result strobe.
// Result strobe done lasts one cycle; the receiver cannot stall.
// Reset: table empty, memory_size 4096. No clearing pass.
`default_nettype none
module contiguous_block_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] req_id,
	input  wire logic [15:0] req_size,
	output logic             done,
	output logic [2:0]       status,
	output logic [15:0]      block_start,
	output logic [15:0]      block_end,
	output logic [15:0]      free_remaining,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import cba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;
	logic [15:0] mem_size;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == RegMemSize);
	assign prdata = (paddr == RegMemSize) ? {16'd0, mem_size} : 32'd0;

	cba_ctrl u_ctrl (.clk, .arst_n, .start, .cfg_wr, .sts, .cmd, .busy);

	cba_dpath u_dpath (.clk, .arst_n, .cmd, .sts, .opcode, .req_id, .req_size,
		.cfg_wr, .cfg_data(pwdata[15:0]), .mem_size, .done, .status,
		.block_start, .block_end, .free_remaining);
endmodule
`default_nettype wire

/* src/cba_checker.sv */
// Port-level assertions for the allocator, bound to the top level.
`default_nettype none
module cba_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [2:0] status,
	input wire logic [15:0] block_start,
	input wire logic [15:0] block_end
);
	import cba_pkg::*;

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> block_start == 16'd0 && block_end == 16'd0)
		else $error("error result not zero");
endmodule

bind contiguous_block_allocator_core cba_checker u_chk (.clk, .arst_n, .start, .busy,
	.done, .status, .block_start, .block_end);
`default_nettype wire

/* tb/tb_contiguous_block_allocator_core.sv */
// Self-checking testbench for the contiguous block allocator core.
`timescale 1ns / 100ps
`default_nettype none
module tb_contiguous_block_allocator_core;
	import cba_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] id;
		logic [15:0] size;
	} req_t;

	typedef struct {
		logic [2:0]  st;
		logic [15:0] s;
		logic [15:0] e;
		logic [15:0] rem;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = '0;
	logic [15:0] req_id = '0;
	logic [15:0] req_size = '0;
	logic done;
	logic [2:0] status;
	logic [15:0] block_start, block_end, free_remaining;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	contiguous_block_allocator_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] tbl_id [MaxBlocks];
	logic [15:0] tbl_lo [MaxBlocks];
	logic [15:0] tbl_hi [MaxBlocks];
	int unsigned used_cnt;
	logic [15:0] mem_total;
	logic [15:0] mem_left;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int gap_pct = 0;
	int mismatches = 0;

	function automatic int unsigned hole_base(int unsigned h);
		return (h == 0) ? 0 : tbl_hi[h-1];
	endfunction

	function automatic int unsigned hole_stop(int unsigned h);
		return (h < used_cnt) ? tbl_lo[h] : mem_total;
	endfunction

	function automatic rsp_t allocate_predict(req_t r);
		rsp_t o;
		int unsigned h, pick, plen, len, lo, hi;
		bit found;
		o = '{ST_OK, 16'd0, 16'd0, 16'd0};
		found = 0; pick = 0; plen = 0;
		if (r.op == OP_FIRST || r.op == OP_BEST) begin
			if (r.size > mem_left) o.st = ST_NOMEM;
			else begin
				for (int i = 0; i < used_cnt; i++)
					if (tbl_id[i] == r.id) o.st = ST_DUP;
				if (o.st == ST_OK && used_cnt >= MaxBlocks) o.st = ST_FULL;
				if (o.st == ST_OK) begin
					for (h = 0; h <= used_cnt; h++) begin
						lo = hole_base(h); hi = hole_stop(h);
						len = (hi > lo) ? hi - lo : 0;
						if (!(found && r.op == OP_FIRST) && r.size <= len &&
						    (!found || len < plen)) begin
							pick = h; plen = len; found = 1;
						end
					end
					if (!found) o.st = ST_NOHOLE;
					else begin
						lo = hole_base(pick);
						for (int i = used_cnt; i > pick; i--) begin
							tbl_id[i] = tbl_id[i-1];
							tbl_lo[i] = tbl_lo[i-1];
							tbl_hi[i] = tbl_hi[i-1];
						end
						tbl_id[pick] = r.id;
						tbl_lo[pick] = lo[15:0];
						tbl_hi[pick] = 16'(lo + r.size);
						used_cnt++;
						mem_left = mem_left - r.size;
						o.s = tbl_lo[pick]; o.e = tbl_hi[pick];
					end
				end
			end
		end else if (r.op == OP_FREE) begin
			o.st = ST_NOTFOUND;
			for (int i = 0; i < used_cnt; i++)
				if (o.st == ST_NOTFOUND && tbl_id[i] == r.id) begin
					o.st = ST_OK; o.s = tbl_lo[i]; o.e = tbl_hi[i];
					for (int j = i; j + 1 < used_cnt; j++) begin
						tbl_id[j] = tbl_id[j+1];
						tbl_lo[j] = tbl_lo[j+1];
						tbl_hi[j] = tbl_hi[j+1];
					end
					used_cnt--;
					mem_left = mem_left + ((o.e > o.s) ? o.e - o.s : 16'd0);
				end
		end else begin
			lo = 0;
			for (int i = 0; i < used_cnt; i++) begin
				len = (tbl_hi[i] > tbl_lo[i]) ? tbl_hi[i] - tbl_lo[i] : 0;
				tbl_lo[i] = lo[15:0];
				tbl_hi[i] = 16'(lo + len);
				lo = tbl_hi[i];
			end
			o.e = lo[15:0];
		end
		if (o.st != ST_OK) begin o.s = 0; o.e = 0; end
		o.rem = mem_left;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_rsps.push_back(allocate_predict(pending_reqs.pop_front()));
		end
		if ((!start || !busy) && pending_reqs.size() > 0 && arst_n &&
		    !(start && !busy && pending_reqs.size() == 0) &&
		    $urandom_range(99) >= gap_pct) begin
			start <= 1'b1;
			opcode <= pending_reqs[0].op;
			req_id <= pending_reqs[0].id;
			req_size <= pending_reqs[0].size;
		end else if (!start || !busy) begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t x;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word st=%0d", status);
			end else begin
				x = expected_rsps.pop_front();
				if (status !== x.st || block_start !== x.s || block_end !== x.e ||
				    free_remaining !== x.rem) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d s=%0d e=%0d rem=%0d got %0d %0d %0d %0d",
							x.st, x.s, x.e, x.rem, status, block_start, block_end,
							free_remaining);
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_mem_size(logic [15:0] v);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= RegMemSize; pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mem_total = v; mem_left = v; used_cnt = 0;
		@(posedge clk);
	endtask

	task automatic add_req(logic [1:0] op, logic [15:0] id, logic [15:0] size);
		req_t r;
		r.op = op; r.id = id; r.size = size;
		pending_reqs.push_back(r);
	endtask

	task automatic random_phase(int n, int gp, logic [15:0] msz);
		logic [15:0] sz;
		gap_pct = gp;
		set_mem_size(msz);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) sz = 16'($urandom);
			else sz = 16'($urandom_range(msz / 8 + 1));
			case ($urandom_range(9))
				0, 1, 2: add_req(OP_FIRST, 16'($urandom_range(23)), sz);
				3, 4, 5: add_req(OP_BEST, 16'($urandom_range(23)), sz);
				6, 7: add_req(OP_FREE, 16'($urandom_range(23)), 16'($urandom));
				8: add_req(OP_DEFRAG, 16'($urandom), 16'($urandom));
				default: add_req(2'($urandom), 16'($urandom), 16'($urandom));
			endcase
		end
		wait_drained();
	endtask

	initial begin
		mem_total = 4096; mem_left = 4096; used_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: default size, extremes, every op and status
		add_req(OP_FIRST, 16'hFFFF, 16'd0);
		add_req(OP_FIRST, 16'hFFFF, 16'd10);
		add_req(OP_FIRST, 16'd0, 16'hFFFF);
		add_req(OP_FIRST, 16'd1, 16'd100);
		add_req(OP_FIRST, 16'd2, 16'd50);
		add_req(OP_FIRST, 16'd3, 16'd200);
		add_req(OP_FREE, 16'd1, 16'd0);
		add_req(OP_FREE, 16'd1, 16'd0);
		add_req(OP_BEST, 16'd4, 16'd40);
		add_req(OP_FIRST, 16'd5, 16'd3700);
		add_req(OP_DEFRAG, 16'd0, 16'd0);
		add_req(OP_FIRST, 16'd5, 16'd3700);
		add_req(OP_BEST, 16'd6, 16'd0);
		wait_drained();
		set_mem_size(16'hFFFF);
		for (int i = 0; i < 17; i++) add_req(OP_BEST, 16'(i + 100), 16'd1);
		add_req(OP_FREE, 16'hABCD, 16'd0);
		add_req(OP_DEFRAG, 16'hFFFF, 16'hFFFF);
		wait_drained();
		set_mem_size(16'd0);
		add_req(OP_FIRST, 16'd1, 16'd0);
		add_req(OP_FIRST, 16'd2, 16'd1);
		wait_drained();
		random_phase(450, 0, 16'd256);
		random_phase(450, 49, 16'd4096);
		random_phase(450, 27, 16'hFFFF);
		random_phase(450, 0, 16'd64);
		if (mismatches == 0 && expected_rsps.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

/* contiguous_block_allocator_core.f */
src/cba_pkg.sv
src/cba_ctrl.sv
src/cba_dpath.sv
src/contiguous_block_allocator_core.sv
src/cba_checker.sv
tb/tb_contiguous_block_allocator_core.sv
